// ----- design/fawm_pkg.sv -----
`timescale 1ns / 1ps
package fawm_pkg;

  // correlation index and weight widths are fixed by the item format
  localparam int unsigned CorrW   = 2;
  localparam int unsigned WeightW = 32;
  localparam int unsigned CountW  = 16;
  localparam int unsigned SumW    = 48;

  // largest vector length that is counted; extra samples are dropped
  localparam int unsigned MaxChannels = 65535;
  localparam int unsigned CountLimitInt =
    (MaxChannels > 65535) ? 65535 : ((MaxChannels < 1) ? 1 : MaxChannels);
  localparam logic [CountW-1:0] CountLimit = CountW'(CountLimitInt);

  // quotient bits produced by the divider, one per step
  localparam int unsigned DivSteps = WeightW;
  localparam int unsigned StepW    = $clog2(DivSteps);

  // one finished vector waiting for its division
  typedef struct packed {
    logic [CorrW-1:0]  corr;
    logic [SumW-1:0]   sum;
    logic [CountW-1:0] divisor;
  } mean_req_t;

endpackage

// ----- design/fawm_fifo.sv -----
`timescale 1ns / 1ps
module fawm_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  fawm_pkg::mean_req_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output fawm_pkg::mean_req_t head_o,
  output logic                empty_o
);

  fawm_pkg::mean_req_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- design/fawm_front.sv -----
`timescale 1ns / 1ps
module fawm_front #(
  parameter int NUM_CORRELATIONS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [fawm_pkg::CorrW-1:0]    corr_index_i,
  input  logic [fawm_pkg::WeightW-1:0]  weight_i,
  input  logic                          flagged_i,
  input  logic                          first_channel_i,
  input  logic                          last_channel_i,
  output logic                          req_valid_o,
  output fawm_pkg::mean_req_t           req_o
);

  // only indices the port can carry are ever stored
  localparam int NumEntries = (NUM_CORRELATIONS < 4) ? NUM_CORRELATIONS : 4;
  localparam int IdxW       = (NumEntries > 1) ? $clog2(NumEntries) : 1;

  logic                        mode_q [NumEntries];
  logic [fawm_pkg::CountW-1:0] cnt_q  [NumEntries];
  logic [fawm_pkg::SumW-1:0]   sum_q  [NumEntries];

  logic                        in_range;
  logic [IdxW-1:0]             idx;
  logic                        cur_mode, new_mode;
  logic [fawm_pkg::CountW-1:0] cur_cnt, new_cnt;
  logic [fawm_pkg::SumW-1:0]   cur_sum, new_sum, acc_sum;
  logic                        can_acc;

  assign in_range = (32'(corr_index_i) < 32'(NUM_CORRELATIONS));
  assign idx      = IdxW'(corr_index_i);

  always_comb begin
    // a first-channel mark starts from a clean entry
    cur_mode = first_channel_i ? 1'b1 : mode_q[idx];
    cur_cnt  = first_channel_i ? '0 : cnt_q[idx];
    cur_sum  = first_channel_i ? '0 : sum_q[idx];
    can_acc  = (cur_cnt < fawm_pkg::CountLimit);
    acc_sum  = cur_sum + {{(fawm_pkg::SumW - fawm_pkg::WeightW){1'b0}}, weight_i};
    new_mode = cur_mode;
    new_cnt  = cur_cnt;
    new_sum  = cur_sum;
    if (cur_mode && !flagged_i) begin
      // first good sample restarts the mean with itself
      new_mode = 1'b0;
      new_cnt  = fawm_pkg::CountW'(1);
      new_sum  = {{(fawm_pkg::SumW - fawm_pkg::WeightW){1'b0}}, weight_i};
    end else if ((cur_mode == flagged_i) && can_acc) begin
      new_cnt = cur_cnt + fawm_pkg::CountW'(1);
      new_sum = acc_sum;
    end
  end

  assign req_valid_o     = accept_i && in_range && last_channel_i;
  assign req_o.corr      = corr_index_i;
  assign req_o.sum       = new_sum;
  assign req_o.divisor   = (new_cnt == '0) ? fawm_pkg::CountW'(1) : new_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumEntries; i++) begin
        mode_q[i] <= 1'b1;
        cnt_q[i]  <= '0;
        sum_q[i]  <= '0;
      end
    end else if (accept_i && in_range) begin
      if (last_channel_i) begin
        mode_q[idx] <= 1'b1;
        cnt_q[idx]  <= '0;
        sum_q[idx]  <= '0;
      end else begin
        mode_q[idx] <= new_mode;
        cnt_q[idx]  <= new_cnt;
        sum_q[idx]  <= new_sum;
      end
    end
  end

endmodule

// ----- design/fawm_back.sv -----
`timescale 1ns / 1ps
module fawm_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fawm_pkg::mean_req_t           req_i,
  input  logic                          req_empty_i,
  output logic                          req_pop_o,
  output logic                          empty_o,
  input  logic                          pop_i,
  output logic [fawm_pkg::CorrW-1:0]    out_corr_index_o,
  output logic [fawm_pkg::WeightW-1:0]  mean_weight_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  state_e                       state_q;
  logic [fawm_pkg::StepW-1:0]   step_q;
  logic [fawm_pkg::CountW-1:0]  rem_q;
  logic [fawm_pkg::WeightW-1:0] quo_q;
  logic [fawm_pkg::CountW-1:0]  div_q;
  logic [fawm_pkg::CorrW-1:0]   corr_q;
  logic                         out_valid_q;
  logic [fawm_pkg::CorrW-1:0]   out_corr_q;
  logic [fawm_pkg::WeightW-1:0] out_mean_q;

  logic [fawm_pkg::CountW:0]    trial;
  logic [fawm_pkg::CountW:0]    trial_diff;
  logic                         qbit;
  logic                         load_out;

  assign req_pop_o        = (state_q == ST_IDLE) && !req_empty_i;
  assign empty_o          = !out_valid_q;
  assign out_corr_index_o = out_corr_q;
  assign mean_weight_o    = out_mean_q;

  // finished quotient moves to the output register when that is free or popped
  assign load_out = (state_q == ST_DONE) && (!out_valid_q || pop_i);

  // restoring step: bring down one dividend bit, subtract if it fits
  assign trial      = {rem_q, quo_q[fawm_pkg::WeightW-1]};
  assign trial_diff = trial - {1'b0, div_q};
  assign qbit       = (trial >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      div_q       <= '0;
      corr_q      <= '0;
      out_valid_q <= 1'b0;
      out_corr_q  <= '0;
      out_mean_q  <= '0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (!req_empty_i) begin
            // upper sum bits are always below the count, so 32 steps do
            rem_q   <= req_i.sum[fawm_pkg::SumW-1:fawm_pkg::WeightW];
            quo_q   <= req_i.sum[fawm_pkg::WeightW-1:0];
            div_q   <= req_i.divisor;
            corr_q  <= req_i.corr;
            step_q  <= '0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          rem_q  <= qbit ? trial_diff[fawm_pkg::CountW-1:0] : trial[fawm_pkg::CountW-1:0];
          quo_q  <= {quo_q[fawm_pkg::WeightW-2:0], qbit};
          step_q <= step_q + fawm_pkg::StepW'(1);
          if (step_q == fawm_pkg::StepW'(fawm_pkg::DivSteps - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            out_corr_q  <= corr_q;
            out_mean_q  <= quo_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/flag_aware_weight_mean.sv -----
`timescale 1ns / 1ps
// Per-correlation mean of unsigned Q16.16 weight samples that honors flags.
// Samples of up to NUM_CORRELATIONS (at most four, as the index is 2 bits)
// vectors may arrive interleaved; a sample with last_channel set yields one
// item holding its correlation and sum / count truncated, anything else yields
// nothing, and an index at or above NUM_CORRELATIONS is dropped. A vector
// counts all samples until its first unflagged one, which restarts the mean;
// later flagged samples are ignored. Counts stop at 65535 samples.
// Rate: the front takes one item per cycle whenever full is low. Each
// end-of-vector item then passes through the back end in order: it is
// loaded, the one-bit-per-cycle restoring divider runs over all quotient
// bits, and the quotient is handed to the output register once that is free
// or popped. A two-entry queue sits between front and divider, so vector
// ends that come faster than the divider finishes them eventually raise full,
// which stalls every item, until the divider catches up.
module flag_aware_weight_mean #(
  parameter int NUM_CORRELATIONS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input side, queue style
  input  logic                          push,
  output logic                          full,
  input  logic [fawm_pkg::CorrW-1:0]    corr_index_i,
  input  logic [fawm_pkg::WeightW-1:0]  weight_i,
  input  logic                          flagged_i,
  input  logic                          first_channel_i,
  input  logic                          last_channel_i,
  // result side, queue style
  output logic                          empty,
  input  logic                          pop,
  output logic [fawm_pkg::CorrW-1:0]    out_corr_index_o,
  output logic [fawm_pkg::WeightW-1:0]  mean_weight_o
);

  logic                accept;
  logic                req_valid;
  fawm_pkg::mean_req_t req;
  fawm_pkg::mean_req_t req_head;
  logic                req_empty;
  logic                req_pop;

  // every item stalls while the queue is full, whether or not it ends a vector
  assign accept = push && !full;

  // front: per-correlation mode, count and sum, one item per cycle while full is low
  fawm_front #(
    .NUM_CORRELATIONS (NUM_CORRELATIONS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .corr_index_i    (corr_index_i),
    .weight_i        (weight_i),
    .flagged_i       (flagged_i),
    .first_channel_i (first_channel_i),
    .last_channel_i  (last_channel_i),
    .req_valid_o     (req_valid),
    .req_o           (req)
  );

  // finished vectors waiting for the divider
  fawm_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (req_valid),
    .push_data_i (req),
    .full_o      (full),
    .pop_i       (req_pop),
    .head_o      (req_head),
    .empty_o     (req_empty)
  );

  // back: serial divider and output register
  fawm_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (req_head),
    .req_empty_i      (req_empty),
    .req_pop_o        (req_pop),
    .empty_o          (empty),
    .pop_i            (pop),
    .out_corr_index_o (out_corr_index_o),
    .mean_weight_o    (mean_weight_o)
  );

endmodule
